// ===== hw/rtl/wcc_pkg.sv =====
// Shared types and constants for the weighted clustering coefficient block.
package wcc_pkg;
    localparam int MAX_NODES_D   = 1024;
    localparam int MAX_DEGREE_D  = 64;
    localparam int WEIGHT_BITS_D = 16;

    localparam int NODE_W  = 10;
    localparam int DEG_W   = 7;
    localparam int STR_W   = 22;
    localparam int WIN_W   = 16;
    localparam int COEF_W  = 17;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_ADD_RD,
        S_ADD_CHK,
        S_ADD_WA,
        S_ADD_WB,
        S_Q_RD,
        S_Q_CHK,
        S_Q_J,
        S_Q_JW,
        S_Q_K,
        S_Q_KW,
        S_Q_DEGM,
        S_Q_DEGW,
        S_Q_SCAN,
        S_Q_SCANW,
        S_Q_DIV,
        S_Q_OUT
    } t_state;
endpackage

// ===== hw/rtl/wcc_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module wcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== hw/rtl/wcc_div.sv =====
// Restoring divider producing a 16-bit Q.16 fraction, one bit per cycle.
module wcc_div #(
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [15:0]   o_quot
);
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [15:0]   r_quot;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic [DW:0]   w_sh;

    assign w_sh   = {r_rem[DW-1:0], 1'b0};
    assign n_rem  = (w_sh >= {1'b0, r_den}) ? w_sh - {1'b0, r_den} : w_sh;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[14:0], (w_sh >= {1'b0, r_den})};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== hw/rtl/weighted_clustering_coefficient.sv =====
// Top level of the weighted clustering coefficient engine.
// The graph sits in four single-port RAMs: per-node degree and strength, and
// per-slot neighbor index and weight. Add-edge steps through S_ADD_RD, S_ADD_CHK,
// S_ADD_WA and S_ADD_WB unless the edge is dropped, clear sweeps every address of
// the degree/strength RAMs, and a query walks all neighbor pairs, scanning the
// neighbor lists one entry at a time through the slot RAM port. busy is high
// for the whole item; the result appears on o_valid for one cycle and cannot
// be stalled. After reset the block runs a clearing pass over every node.
module weighted_clustering_coefficient
    import wcc_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_D,
    parameter int MAX_DEGREE  = MAX_DEGREE_D,
    parameter int WEIGHT_BITS = WEIGHT_BITS_D
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_mode,
    input  logic [NODE_W-1:0] i_node_a,
    input  logic [NODE_W-1:0] i_node_b,
    input  logic [WIN_W-1:0]  i_weight,
    output logic              o_valid,
    output logic [NODE_W-1:0] o_node,
    output logic [DEG_W-1:0]  o_degree,
    output logic [STR_W-1:0]  o_strength,
    output logic [COEF_W-1:0] o_coefficient,
    output logic              o_undefined_value,
    output logic              o_saturated,
    output logic              o_edges_dropped
);
    localparam int NA   = $clog2(MAX_NODES);
    localparam int DA   = $clog2(MAX_DEGREE);
    localparam int SA   = NA + DA;
    localparam int DGW  = $clog2(MAX_DEGREE + 1);
    localparam int SW   = WEIGHT_BITS + DGW;
    localparam int SUMW = WEIGHT_BITS + 1 + 2 * DGW;
    localparam int DENW = SW + DGW;
    localparam int DVW  = (SUMW > DENW) ? SUMW : DENW;

    t_state r_state, n_state;

    logic [NA:0]           r_cnt, n_cnt;
    logic [1:0]            r_mode, n_mode;
    logic [NODE_W-1:0]     r_a, n_a, r_b, n_b;
    logic [WEIGHT_BITS-1:0] r_w, n_w;
    logic                  r_drop, n_drop;
    logic [DGW-1:0]        r_dega, n_dega, r_degb, n_degb;
    logic [SW-1:0]         r_stra, n_stra, r_strb, n_strb;
    logic [DGW-1:0]        r_j, n_j, r_k, n_k, r_m, n_m, r_degj, n_degj;
    logic [NA-1:0]         r_nj, n_nj, r_nk, n_nk;
    logic [WEIGHT_BITS-1:0] r_wj, n_wj, r_wk, n_wk;
    logic [SUMW-1:0]       r_sum, n_sum;
    logic [DENW-1:0]       r_den, n_den;
    logic                  r_out, n_out, r_sat, n_sat, r_undef, n_undef;
    logic [COEF_W-1:0]     r_coef, n_coef;

    logic                  dg_we, st_we, sl_we, sw_we;
    logic [NA-1:0]         dg_addr;
    logic [DGW-1:0]        dg_wd, dg_rd;
    logic [SW-1:0]         st_wd, st_rd;
    logic [SA-1:0]         sl_addr;
    logic [NA-1:0]         sl_wd, sl_rd;
    logic [WEIGHT_BITS-1:0] sw_wd, sw_rd;
    logic                  dv_start, dv_done;
    logic [15:0]           dv_q;
    logic                  a_ok, b_ok;

    wcc_ram #(.WIDTH(DGW), .DEPTH(MAX_NODES)) u_deg (
        .i_clk, .i_we(dg_we), .i_addr(dg_addr), .i_wdata(dg_wd), .o_rdata(dg_rd));
    wcc_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_str (
        .i_clk, .i_we(st_we), .i_addr(dg_addr), .i_wdata(st_wd), .o_rdata(st_rd));
    wcc_ram #(.WIDTH(NA), .DEPTH(MAX_NODES * MAX_DEGREE)) u_nbr (
        .i_clk, .i_we(sl_we), .i_addr(sl_addr), .i_wdata(sl_wd), .o_rdata(sl_rd));
    wcc_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_NODES * MAX_DEGREE)) u_wgt (
        .i_clk, .i_we(sw_we), .i_addr(sl_addr), .i_wdata(sw_wd), .o_rdata(sw_rd));
    wcc_div #(.DW(DVW)) u_div (
        .i_clk, .i_rst_n, .i_start(dv_start),
        .i_num(DVW'(r_sum)), .i_den(DVW'(r_den)), .o_done(dv_done), .o_quot(dv_q));

    assign a_ok = 32'(r_a) < MAX_NODES;
    assign b_ok = 32'(r_b) < MAX_NODES;
    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_out   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_out   <= n_out;
        end
        r_mode <= n_mode; r_a <= n_a; r_b <= n_b; r_w <= n_w;
        r_dega <= n_dega; r_degb <= n_degb; r_stra <= n_stra; r_strb <= n_strb;
        r_j <= n_j; r_k <= n_k; r_m <= n_m; r_degj <= n_degj;
        r_nj <= n_nj; r_nk <= n_nk; r_wj <= n_wj; r_wk <= n_wk;
        r_sum <= n_sum; r_den <= n_den; r_sat <= n_sat; r_undef <= n_undef;
        r_coef <= n_coef;
    end

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_mode = r_mode; n_a = r_a; n_b = r_b;
        n_w = r_w; n_drop = r_drop; n_dega = r_dega; n_degb = r_degb;
        n_stra = r_stra; n_strb = r_strb; n_j = r_j; n_k = r_k; n_m = r_m;
        n_degj = r_degj; n_nj = r_nj; n_nk = r_nk; n_wj = r_wj; n_wk = r_wk;
        n_sum = r_sum; n_den = r_den; n_sat = r_sat; n_undef = r_undef;
        n_coef = r_coef; n_out = 1'b0;
        dg_we = 1'b0; st_we = 1'b0; sl_we = 1'b0; sw_we = 1'b0;
        dg_addr = r_a[NA-1:0]; dg_wd = '0; st_wd = '0;
        sl_addr = '0; sl_wd = '0; sw_wd = '0; dv_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_mode = i_mode; n_a = i_node_a; n_b = i_node_b;
                    n_w = i_weight[WEIGHT_BITS-1:0];
                    unique case (t_mode'(i_mode))
                        MODE_CLEAR: begin
                            n_cnt = '0; n_drop = 1'b0; n_state = S_CLR;
                        end
                        MODE_ADD:   n_state = S_ADD_RD;
                        MODE_QUERY: n_state = S_Q_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                dg_addr = r_cnt[NA-1:0]; dg_we = 1'b1; st_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (32'(r_cnt) == MAX_NODES - 1) n_state = S_IDLE;
            end
            S_ADD_RD: begin
                if (!a_ok || !b_ok) begin
                    n_drop = 1'b1; n_state = S_IDLE;
                end else begin
                    dg_addr = r_a[NA-1:0]; n_state = S_ADD_CHK;
                end
            end
            S_ADD_CHK: begin
                n_dega = dg_rd; n_stra = st_rd;
                dg_addr = r_b[NA-1:0]; n_state = S_ADD_WA;
            end
            S_ADD_WA: begin
                n_degb = dg_rd; n_strb = st_rd;
                if (r_a == r_b) begin
                    if (32'(r_dega) + 2 > MAX_DEGREE) begin
                        n_drop = 1'b1; n_state = S_IDLE;
                    end else begin
                        n_degb = r_dega + 1'b1; n_strb = r_stra + SW'(r_w);
                        sl_addr = {r_a[NA-1:0], r_dega[DA-1:0]};
                        sl_we = 1'b1; sw_we = 1'b1; sl_wd = r_b[NA-1:0]; sw_wd = r_w;
                        n_state = S_ADD_WB;
                    end
                end else if (32'(r_dega) + 1 > MAX_DEGREE || 32'(dg_rd) + 1 > MAX_DEGREE) begin
                    n_drop = 1'b1; n_state = S_IDLE;
                end else begin
                    dg_addr = r_a[NA-1:0]; dg_we = 1'b1; st_we = 1'b1;
                    dg_wd = r_dega + 1'b1; st_wd = r_stra + SW'(r_w);
                    sl_addr = {r_a[NA-1:0], r_dega[DA-1:0]};
                    sl_we = 1'b1; sw_we = 1'b1; sl_wd = r_b[NA-1:0]; sw_wd = r_w;
                    n_state = S_ADD_WB;
                end
            end
            S_ADD_WB: begin
                dg_addr = r_b[NA-1:0]; dg_we = 1'b1; st_we = 1'b1;
                dg_wd = r_degb + 1'b1; st_wd = r_strb + SW'(r_w);
                sl_addr = {r_b[NA-1:0], r_degb[DA-1:0]};
                sl_we = 1'b1; sw_we = 1'b1; sl_wd = r_a[NA-1:0]; sw_wd = r_w;
                n_state = S_IDLE;
            end
            S_Q_RD: begin
                dg_addr = r_a[NA-1:0]; n_state = S_Q_CHK;
            end
            S_Q_CHK: begin
                n_dega = a_ok ? dg_rd : '0; n_stra = a_ok ? st_rd : '0;
                n_sum = '0; n_sat = 1'b0; n_coef = '0; n_undef = 1'b1; n_j = '0;
                if (!a_ok || dg_rd < 2 || st_rd == '0) begin
                    n_state = S_Q_OUT;
                end else begin
                    n_undef = 1'b0; n_state = S_Q_J;
                end
            end
            S_Q_J: begin
                if (r_j + 1'b1 >= r_dega) begin
                    n_den = DENW'(r_stra) * DENW'(r_dega - 1'b1);
                    n_state = S_Q_DIV;
                end else begin
                    sl_addr = {r_a[NA-1:0], r_j[DA-1:0]}; n_state = S_Q_JW;
                end
            end
            S_Q_JW: begin
                n_nj = sl_rd; n_wj = sw_rd; n_k = r_j + 1'b1; n_state = S_Q_K;
            end
            S_Q_K: begin
                if (r_k >= r_dega) begin
                    n_j = r_j + 1'b1; n_state = S_Q_J;
                end else begin
                    sl_addr = {r_a[NA-1:0], r_k[DA-1:0]}; n_state = S_Q_KW;
                end
            end
            S_Q_KW: begin
                n_nk = sl_rd; n_wk = sw_rd; dg_addr = r_nj; n_state = S_Q_DEGM;
            end
            S_Q_DEGM: begin
                n_degj = dg_rd; n_m = '0; n_state = S_Q_SCAN;
            end
            S_Q_SCAN: begin
                if (r_m >= r_degj) begin
                    n_k = r_k + 1'b1; n_state = S_Q_K;
                end else begin
                    sl_addr = {r_nj, r_m[DA-1:0]}; n_state = S_Q_SCANW;
                end
            end
            S_Q_SCANW: begin
                if (sl_rd == r_nk) begin
                    n_sum = r_sum + SUMW'(r_wj) + SUMW'(r_wk);
                    n_k = r_k + 1'b1; n_state = S_Q_K;
                end else begin
                    n_m = r_m + 1'b1; n_state = S_Q_SCAN;
                end
            end
            S_Q_DIV: begin
                if (DENW'(r_sum) > r_den && SUMW'(r_den) <= r_sum) begin
                    n_sat = 1'b1; n_coef = COEF_W'(65536); n_state = S_Q_OUT;
                end else if (DVW'(r_sum) > DVW'(r_den)) begin
                    n_sat = 1'b1; n_coef = COEF_W'(65536); n_state = S_Q_OUT;
                end else if (DVW'(r_sum) == DVW'(r_den)) begin
                    n_coef = COEF_W'(65536); n_state = S_Q_OUT;
                end else begin
                    dv_start = 1'b1; n_state = S_Q_OUT; n_cnt = '0;
                    n_mode = MODE_NONE;
                end
            end
            S_Q_OUT: begin
                if (r_mode == MODE_NONE) begin
                    if (dv_done) begin
                        n_coef = {1'b0, dv_q}; n_out = 1'b1; n_state = S_IDLE;
                    end
                end else begin
                    n_out = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid           = r_out;
    assign o_node            = r_a;
    assign o_degree          = DEG_W'(r_dega);
    assign o_strength        = STR_W'(r_stra);
    assign o_coefficient     = r_coef;
    assign o_undefined_value = r_undef;
    assign o_saturated       = r_sat;
    assign o_edges_dropped   = r_drop;
endmodule
